// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the page table walker RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds on every rising edge outside reset.
`define PTW_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define PTW_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define PTW_ASSERT(lbl, clk, rst_n, prop, msg)
`define PTW_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== rtl/ptw_pkg.sv =====
// ----------------------------------------------------------------------------
// ptw_pkg
// Types, field widths and helpers shared by the Sv39 walker modules.
// ----------------------------------------------------------------------------
package ptw_pkg;

	localparam int VA_W        = 39;
	localparam int PA_W        = 56;
	localparam int PPN_W       = 44;
	localparam int PTE_W       = 64;
	localparam int IDX_W       = 9;
	localparam int OFF_W       = 12;
	localparam int WIDX_W      = 13;
	localparam int ENTRIES     = 512;
	localparam int PTE_V_BIT   = 0;
	localparam int PTE_PPN_LSB = 10;
	localparam int NIB_W       = 4;
	localparam int PPN_NIBBLES = PPN_W / NIB_W;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_XLATE = 1'b1;

	localparam logic [1:0] LVL_ROOT = 2'd2;
	localparam logic [1:0] LVL_MID  = 2'd1;
	localparam logic [1:0] LVL_LEAF = 2'd0;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_WAIT,
		ST_RESP
	} ptw_state_t;

	// VPN slice of a virtual address for one level of the walk
	function automatic logic [IDX_W-1:0] vpn_field(input logic [VA_W-1:0] va,
			input logic [1:0] lvl);
		logic [IDX_W-1:0] idx;
		unique case (lvl)
			LVL_ROOT: idx = va[OFF_W+2*IDX_W +: IDX_W];
			LVL_MID:  idx = va[OFF_W+IDX_W +: IDX_W];
			default:  idx = va[OFF_W +: IDX_W];
		endcase
		return idx;
	endfunction

endpackage

// ===== rtl/ptw_store.sv =====
// ----------------------------------------------------------------------------
// ptw_store
// Page table store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ptw_store import ptw_pkg::*; #(
	parameter int TABLE_PAGES = 16
) (
	input  logic                                                        clk,
	input  logic                                                        wr_en,
	input  logic [((TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1)+IDX_W-1:0] wr_addr,
	input  logic [PTE_W-1:0]                                            wr_data,
	input  logic                                                        rd_en,
	input  logic [((TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1)+IDX_W-1:0] rd_addr,
	output logic [PTE_W-1:0]                                            rd_data
);

	localparam int DEPTH = TABLE_PAGES * ENTRIES;

	logic [PTE_W-1:0] mem_q [DEPTH];
	logic [PTE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/ptw_pgmod.sv =====
// ----------------------------------------------------------------------------
// ptw_pgmod
// Reduce a 44-bit page number modulo the store page count, one nibble a cycle.
// ----------------------------------------------------------------------------
module ptw_pgmod import ptw_pkg::*; #(
	parameter int TABLE_PAGES = 16
) (
	input  logic                                                     clk,
	input  logic                                                     arst_n,
	input  logic                                                     start,
	input  logic [PPN_W-1:0]                                         value,
	output logic                                                     done,
	output logic [((TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1)-1:0] page
);

	localparam int PW   = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
	localparam int WR_W = PW + 5;
	localparam int CNT_W = $clog2(PPN_NIBBLES);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PPN_W-1:0] sh_q;
	logic [PW-1:0]    rem_q;
	logic [PW-1:0]    rem_next;
	logic [WR_W-1:0]  t;

	// remainder times 16 plus next nibble, then strip 8N, 4N, 2N, N
	always_comb begin
		t = WR_W'({rem_q, sh_q[PPN_W-1 -: NIB_W]});
		for (int k = 3; k >= 0; k--) begin
			if (t >= WR_W'(TABLE_PAGES << k)) begin
				t = t - WR_W'(TABLE_PAGES << k);
			end
		end
		rem_next = t[PW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(PPN_NIBBLES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= value;
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q  <= sh_q << NIB_W;
			rem_q <= rem_next;
		end
	end

	assign done = done_q;
	assign page = rem_q;

endmodule

// ===== rtl/sv39_page_table_walker_top.sv =====
// ----------------------------------------------------------------------------
// sv39_page_table_walker_top
// Sv39 three-level page table walker over a local page table store.
//
// Input channel (in_valid / in_stall): one beat carries a command. A write
// beat (cmd = 0) stores entry_data at word_index; a translate beat (cmd = 1)
// walks levels 2, 1 and 0 for virt_addr starting at the root_page register.
// Output channel (out_valid / out_stall): one beat per input beat, in order,
// with phys_addr and fault. Writes and faults return phys_addr = 0.
// Config: cfg_we writes cfg_wdata into root_page; write it only while idle.
// Flow: a write is stored when accepted and loads a zero result; a translate
// issues one store read per level, each registered in the store, and loads
// the result at the leaf or at a fault; the result state then moves it to the
// output register. If TABLE_PAGES is not a power of two, each level first
// runs the page number through a nibble-serial reducer.
// Reset: the store is swept to zero, one word a cycle, all TABLE_PAGES * 512
// words (8192 at the default); in_stall stays high until the sweep ends.
// Stall: a finished result waits in the result register; a new beat is taken
// only when idle, or when the output register is empty or drains that cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sv39_page_table_walker_top import ptw_pkg::*; #(
	parameter int TABLE_PAGES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	// config
	input  logic              cfg_we,
	input  logic [PPN_W-1:0]  cfg_wdata,
	// input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              cmd,
	input  logic [WIDX_W-1:0] word_index,
	input  logic [PTE_W-1:0]  entry_data,
	input  logic [VA_W-1:0]   virt_addr,
	// output channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic [PA_W-1:0]   phys_addr,
	output logic              fault
);

	localparam int PW       = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
	localparam int AW       = PW + IDX_W;
	localparam int DEPTH    = TABLE_PAGES * ENTRIES;
	localparam int WR_W     = PW + 5;
	localparam bit PagePow2 = (TABLE_PAGES & (TABLE_PAGES - 1)) == 0;

	// page field of a write index, reduced modulo the page count
	function automatic logic [PW-1:0] wpage_mod(input logic [WIDX_W-IDX_W-1:0] p);
		logic [WR_W-1:0] r;
		r = WR_W'(p);
		for (int k = 3; k >= 0; k--) begin
			if (r >= WR_W'(TABLE_PAGES << k)) begin
				r = r - WR_W'(TABLE_PAGES << k);
			end
		end
		return r[PW-1:0];
	endfunction

	ptw_state_t       state_q, state_d;
	logic [AW-1:0]    clr_addr_q;
	logic [PPN_W-1:0] root_page_q;
	logic [VA_W-1:0]  va_q, va_d;
	logic [1:0]       lvl_q, lvl_d;
	logic [PA_W-1:0]  res_phys_q, res_phys_d;
	logic             res_fault_q, res_fault_d;
	logic             res_load;
	logic             out_valid_q;
	logic [PA_W-1:0]  phys_addr_q;
	logic             fault_q;
	logic             out_load;
	logic             out_free;
	logic             in_accept;

	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [PTE_W-1:0] wr_data;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic [PTE_W-1:0] rd_data;
	logic [PPN_W-1:0] pte_ppn;

	logic             walk_go;
	logic [PPN_W-1:0] walk_ppn;
	logic [PW-1:0]    walk_pg;
	logic             mod_start;
	logic             mod_done;
	logic [PW-1:0]    mod_page;

	ptw_store #(
		.TABLE_PAGES(TABLE_PAGES)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	ptw_pgmod #(
		.TABLE_PAGES(TABLE_PAGES)
	) u_pgmod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mod_start),
		.value (walk_ppn),
		.done  (mod_done),
		.page  (mod_page)
	);

	assign pte_ppn = rd_data[PTE_PPN_LSB +: PPN_W];

	// power-of-two page count: keep the low page bits, no reducer pass
	assign walk_pg = walk_ppn[PW-1:0] & PW'(TABLE_PAGES - 1);

	// output register drains or is empty this cycle
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = !((state_q == ST_IDLE) || (state_q == ST_RESP && out_free));
	assign in_accept = in_valid && !in_stall;

	always_comb begin
		state_d     = state_q;
		va_d        = va_q;
		lvl_d       = lvl_q;
		res_load    = 1'b0;
		res_phys_d  = '0;
		res_fault_d = 1'b0;
		out_load    = 1'b0;
		wr_en       = 1'b0;
		wr_addr     = clr_addr_q;
		wr_data     = '0;
		rd_en       = 1'b0;
		rd_addr     = '0;
		mod_start   = 1'b0;
		walk_go     = 1'b0;
		walk_ppn    = root_page_q;

		unique case (state_q)
			ST_CLEAR: begin
				// sweep zeros through the store after reset
				wr_en = 1'b1;
				if (clr_addr_q == AW'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				// wait for a beat; handled below
			end
			ST_MOD: begin
				if (mod_done) begin
					rd_en   = 1'b1;
					rd_addr = {mod_page, vpn_field(va_q, lvl_q)};
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (!rd_data[PTE_V_BIT]) begin
					// invalid entry at any level: drop the walk, report fault
					res_load    = 1'b1;
					res_fault_d = 1'b1;
					state_d     = ST_RESP;
				end else if (lvl_q == LVL_LEAF) begin
					res_load   = 1'b1;
					res_phys_d = {pte_ppn, va_q[OFF_W-1:0]};
					state_d    = ST_RESP;
				end else begin
					// advance one level down with the entry's PPN
					lvl_d    = lvl_q - 2'd1;
					walk_go  = 1'b1;
					walk_ppn = pte_ppn;
				end
			end
			ST_RESP: begin
				// hold the result until the output register is free
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (in_accept) begin
			if (cmd == CMD_WRITE) begin
				wr_en       = 1'b1;
				wr_addr     = {wpage_mod(word_index[WIDX_W-1:IDX_W]),
					word_index[IDX_W-1:0]};
				wr_data     = entry_data;
				res_load    = 1'b1;
				res_phys_d  = '0;
				res_fault_d = 1'b0;
				state_d     = ST_RESP;
			end else begin
				va_d     = virt_addr;
				lvl_d    = LVL_ROOT;
				walk_go  = 1'b1;
				walk_ppn = root_page_q;
			end
		end

		// issue the next level read, through the reducer when needed
		if (walk_go) begin
			if (PagePow2) begin
				rd_en   = 1'b1;
				rd_addr = {walk_pg, vpn_field(va_d, lvl_d)};
				state_d = ST_WAIT;
			end else begin
				mod_start = 1'b1;
				state_d   = ST_MOD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			root_page_q <= '0;
			lvl_q       <= LVL_ROOT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			lvl_q   <= lvl_d;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (cfg_we) begin
				root_page_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		va_q <= va_d;
		if (res_load) begin
			res_phys_q  <= res_phys_d;
			res_fault_q <= res_fault_d;
		end
		if (out_load) begin
			phys_addr_q <= res_phys_q;
			fault_q     <= res_fault_q;
		end
	end

	assign out_valid = out_valid_q;
	assign phys_addr = phys_addr_q;
	assign fault     = fault_q;

	`PTW_ASSERT(a_out_from_resp, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == ST_RESP), "output beat raised outside the result state")
	`PTW_ASSERT(a_fault_zero_pa, clk, arst_n, (out_valid_q && fault_q) |-> (phys_addr_q == '0), "fault beat carries a nonzero address")
	`PTW_ASSERT(a_read_then_wait, clk, arst_n, rd_en |=> (state_q == ST_WAIT), "store read not followed by the wait state")
	`PTW_NEVER(a_level_range, clk, arst_n, lvl_q == 2'd3, "walk level out of range")

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Sv39 page table walker. A directed table first
// builds a small three-level mapping by hand and walks it through every fault
// level, the all-ones leaf and the page-number wrap. Random phases then build
// walk chains under several root pages, mixed with stray writes and unmapped
// translations. Every result beat is checked in order, against the expected
// value of a typed directed row or a shadow-store walk predictor in the bench.
// ----------------------------------------------------------------------------
module testbench import ptw_pkg::*; ();

	localparam int STORE_PAGES = 16;
	localparam int STORE_WORDS = STORE_PAGES * ENTRIES;
	// Allow for the clearing sweep after reset plus plenty of slack.
	localparam int STALL_LIMIT = 50000;
	localparam int PHASES      = 5;
	localparam int PHASE_ITEMS = 190;
	localparam int CALM_FIRST  = 380;
	localparam int CALM_LAST   = 560;

	typedef struct packed {
		logic [PA_W-1:0] pa;
		logic            flt;
	} walk_result_t;

	// One directed beat; when typed is set, pa/flt is the expected result as
	// written here, otherwise the predictor supplies it.
	typedef struct packed {
		logic              op;
		logic [WIDX_W-1:0] widx;
		logic [PTE_W-1:0]  data;
		logic [VA_W-1:0]   va;
		logic              typed;
		logic [PA_W-1:0]   pa;
		logic              flt;
	} plan_row_t;

	localparam int PLAN_LEN = 21;
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		// empty store right after reset: every walk faults at the root
		'{CMD_XLATE, 13'd0, 64'd0, 39'd0, 1'b1, 56'd0, 1'b1},
		'{CMD_XLATE, 13'd0, 64'd0, 39'h7F_FFFF_FFFF, 1'b1, 56'd0, 1'b1},
		// extremes of word index and entry data; writes return zero
		'{CMD_WRITE, 13'h1FFF, 64'hFFFF_FFFF_FFFF_FFFF, 39'd0, 1'b1, 56'd0, 1'b0},
		'{CMD_WRITE, 13'd0, 64'd0, 39'h7F_FFFF_FFFF, 1'b1, 56'd0, 1'b0},
		'{CMD_XLATE, 13'h1FFF, 64'hFFFF_FFFF_FFFF_FFFF, 39'd0, 1'b1, 56'd0, 1'b1},
		// root entry 0 -> page 1, then fault at level 1
		'{CMD_WRITE, 13'd0, 64'h0000_0000_0000_0401, 39'd0, 1'b1, 56'd0, 1'b0},
		'{CMD_XLATE, 13'd0, 64'd0, 39'd0, 1'b1, 56'd0, 1'b1},
		// mid entry with R/W/X set must not stop the walk; fault at leaf
		'{CMD_WRITE, 13'd512, 64'h0000_0000_0000_08CF, 39'd0, 1'b1, 56'd0, 1'b0},
		'{CMD_XLATE, 13'd0, 64'd0, 39'h0ABC, 1'b1, 56'd0, 1'b1},
		// leaf with reserved top bits set; a full walk succeeds
		'{CMD_WRITE, 13'd1024, 64'hFFC2_AF37_848D_14C1, 39'd0, 1'b1, 56'd0, 1'b0},
		'{CMD_XLATE, 13'd77, 64'h1234, 39'h0FFF, 1'b0, 56'd0, 1'b0},
		'{CMD_XLATE, 13'd0, 64'd0, 39'd0, 1'b0, 56'd0, 1'b0},
		// all-ones leaf gives the largest physical address
		'{CMD_WRITE, 13'd1535, 64'hFFFF_FFFF_FFFF_FFFF, 39'd0, 1'b1, 56'd0, 1'b0},
		'{CMD_XLATE, 13'd0, 64'd0, 39'h1F_FFFF, 1'b1, 56'hFF_FFFF_FFFF_FFFF, 1'b0},
		'{CMD_XLATE, 13'd0, 64'd0, 39'hA0_0000, 1'b1, 56'd0, 1'b1},
		// page number with high bits set wraps onto page 1
		'{CMD_WRITE, 13'd1, 64'h003C_0000_0000_4401, 39'd0, 1'b1, 56'd0, 1'b0},
		'{CMD_XLATE, 13'd0, 64'd0, 39'h0_4000_0123, 1'b0, 56'd0, 1'b0},
		// valid bit clear with every other bit set still faults
		'{CMD_WRITE, 13'd2, 64'hFFFF_FFFF_FFFF_FFFE, 39'd0, 1'b1, 56'd0, 1'b0},
		'{CMD_XLATE, 13'd0, 64'd0, 39'h0_8000_0000, 1'b1, 56'd0, 1'b1},
		// root entry 3 -> page 15, whose last entry points back to page 15
		'{CMD_WRITE, 13'd3, 64'h0000_0000_0000_3C01, 39'd0, 1'b1, 56'd0, 1'b0},
		'{CMD_XLATE, 13'd0, 64'd0, 39'h0_FFFF_F123, 1'b0, 56'd0, 1'b0}
	};

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              cfg_we     = 1'b0;
	logic [PPN_W-1:0]  cfg_wdata  = '0;
	logic              in_valid   = 1'b0;
	logic              cmd        = CMD_WRITE;
	logic [WIDX_W-1:0] word_index = '0;
	logic [PTE_W-1:0]  entry_data = '0;
	logic [VA_W-1:0]   virt_addr  = '0;
	logic              out_stall  = 1'b0;
	wire               in_stall;
	wire               out_valid;
	wire  [PA_W-1:0]   phys_addr;
	wire               fault;

	// Shadow copy of the block's state and the results still owed by it.
	logic [PTE_W-1:0]  pte_shadow [STORE_WORDS];
	logic [PPN_W-1:0]  root_shadow = '0;
	walk_result_t      walk_results_q [$];
	logic [VA_W-1:0]   mapped_va_q [$];

	int errors       = 0;
	int beats_sent   = 0;
	int quiet_cycles = 0;
	bit calm         = 1'b0;

	always #5 clk = ~clk;

	sv39_page_table_walker_top #(
		.TABLE_PAGES(STORE_PAGES)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.word_index (word_index),
		.entry_data (entry_data),
		.virt_addr  (virt_addr),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.phys_addr  (phys_addr),
		.fault      (fault)
	);

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Apply one beat to the shadow store and return the result the block owes.
	function automatic walk_result_t walk_model(input logic op, input logic [WIDX_W-1:0] w,
			input logic [PTE_W-1:0] d, input logic [VA_W-1:0] va);
		walk_result_t     r;
		logic [PPN_W-1:0] pg;
		logic [PTE_W-1:0] e;
		int               lvl;
		int unsigned      sel;
		r = '0;
		if (op == CMD_WRITE) begin
			pte_shadow[w % STORE_WORDS] = d;
			return r;
		end
		pg = root_shadow;
		for (lvl = 2; lvl >= 0; lvl--) begin
			sel = (pg % STORE_PAGES) * ENTRIES + va[OFF_W + IDX_W * lvl +: IDX_W];
			e = pte_shadow[sel];
			if (!e[PTE_V_BIT]) begin
				r.flt = 1'b1;
				return r;
			end
			pg = e[PTE_PPN_LSB +: PPN_W];
		end
		r.pa = {pg, va[OFF_W-1:0]};
		return r;
	endfunction

	// Drive one beat, hold it until accepted, then log the result it owes.
	task automatic send_beat(input logic op, input logic [WIDX_W-1:0] w,
			input logic [PTE_W-1:0] d, input logic [VA_W-1:0] va,
			input logic typed, input logic [PA_W-1:0] tpa, input logic tflt);
		walk_result_t r;
		// random sender gaps, skipped inside the calm stretch
		if (!calm) begin
			while ($urandom_range(99) < 7) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid   <= 1'b1;
		cmd        <= op;
		word_index <= w;
		entry_data <= d;
		virt_addr  <= va;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		r = walk_model(op, w, d, va);
		if (typed) begin
			r.pa  = tpa;
			r.flt = tflt;
		end
		walk_results_q.push_back(r);
		beats_sent++;
		calm = (beats_sent >= CALM_FIRST && beats_sent < CALM_LAST);
	endtask

	// Hold the sender off until every owed result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (walk_results_q.size() != 0) @(posedge clk);
	endtask

	// Program root_page; only done with the block idle.
	task automatic set_root(input logic [PPN_W-1:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		root_shadow = v;
	endtask

	// Release reset once at the start; it is never asserted again.
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Receiver stalls at random, except through the calm stretch.
	always @(posedge clk) begin
		out_stall <= arst_n && !calm && ($urandom_range(99) < 7);
	end

	// Check each result beat against the oldest owed result, and watch for hangs.
	always @(posedge clk) begin : check_results
		walk_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (walk_results_q.size() == 0) begin
				$error("result beat with nothing owed: phys_addr %h fault %b",
					phys_addr, fault);
				errors++;
			end else begin
				want = walk_results_q.pop_front();
				if (phys_addr !== want.pa) begin
					$error("phys_addr: expected %h, got %h", want.pa, phys_addr);
					errors++;
				end
				if (fault !== want.flt) begin
					$error("fault: expected %b, got %b", want.flt, fault);
					errors++;
				end
			end
		end
		// any beat on either channel resets the watchdog
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int                i;
		int                phase;
		int                phase_end;
		int                kind;
		int                lvl_break;
		int                n_walks;
		int                k;
		bit                broken;
		bit                skip_write;
		int unsigned       sel;
		logic [63:0]       rnd;
		logic [VA_W-1:0]   va;
		logic [PPN_W-1:0]  root_now;
		logic [PPN_W-1:0]  ppn1;
		logic [PPN_W-1:0]  ppn2;
		logic [PPN_W-1:0]  leaf_ppn;
		logic [PTE_W-1:0]  pte [3];
		logic [WIDX_W-1:0] wsel [3];

		// store clears on reset, so the shadow starts all invalid
		for (i = 0; i < STORE_WORDS; i++) pte_shadow[i] = '0;

		// wait out reset and the clearing sweep
		@(posedge clk);
		while (arst_n !== 1'b1 || in_stall !== 1'b0) @(posedge clk);

		// directed table under root page 0
		set_root('0);
		for (i = 0; i < PLAN_LEN; i++) begin
			send_beat(PLAN[i].op, PLAN[i].widx, PLAN[i].data, PLAN[i].va,
				PLAN[i].typed, PLAN[i].pa, PLAN[i].flt);
		end

		// random phases, each under its own root page
		for (phase = 0; phase < PHASES; phase++) begin
			rnd = rand64();
			case (phase)
				0: root_now = '1;
				2: root_now = '0;
				3: root_now = {rnd[PPN_W-1:8], 8'd0} | PPN_W'($urandom_range(15));
				default: root_now = rnd[PPN_W-1:0];
			endcase
			set_root(root_now);
			phase_end = PLAN_LEN + (phase + 1) * PHASE_ITEMS;

			while (beats_sent < phase_end) begin
				kind = $urandom_range(99);
				if (kind < 55) begin
					// build a three-level chain for a random address, then walk it
					rnd = rand64();
					va = rnd[VA_W-1:0];
					rnd = rand64();
					ppn1 = rnd[PPN_W-1:0];
					rnd = rand64();
					ppn2 = rnd[PPN_W-1:0];
					rnd = rand64();
					leaf_ppn = rnd[PPN_W-1:0];
					if ($urandom_range(1)) ppn1[PPN_W-1:4] = '0;
					if ($urandom_range(1)) ppn2[PPN_W-1:4] = '0;
					rnd = rand64();
					pte[0] = {rnd[63:54], ppn1, rnd[9:1], 1'b1};
					rnd = rand64();
					pte[1] = {rnd[63:54], ppn2, rnd[9:1], 1'b1};
					rnd = rand64();
					pte[2] = {rnd[63:54], leaf_ppn, rnd[9:1], 1'b1};
					sel = (root_shadow % STORE_PAGES) * ENTRIES + va[38:30];
					wsel[0] = sel[WIDX_W-1:0];
					sel = (ppn1 % STORE_PAGES) * ENTRIES + va[29:21];
					wsel[1] = sel[WIDX_W-1:0];
					sel = (ppn2 % STORE_PAGES) * ENTRIES + va[20:12];
					wsel[2] = sel[WIDX_W-1:0];
					// break some chains: clear a valid bit or leave a level unwritten
					broken = ($urandom_range(99) < 20);
					lvl_break = $urandom_range(2);
					skip_write = broken && $urandom_range(1);
					if (broken && !skip_write) pte[lvl_break][PTE_V_BIT] = 1'b0;
					for (k = 0; k < 3; k++) begin
						if (!(skip_write && k == lvl_break)) begin
							rnd = rand64();
							send_beat(CMD_WRITE, wsel[k], pte[k], rnd[VA_W-1:0],
								1'b0, '0, 1'b0);
						end
					end
					n_walks = $urandom_range(1, 3);
					for (k = 0; k < n_walks; k++) begin
						rnd = rand64();
						va[OFF_W-1:0] = rnd[OFF_W-1:0];
						send_beat(CMD_XLATE, rnd[WIDX_W+11:12], rand64(), va,
							1'b0, '0, 1'b0);
					end
					if (!broken) begin
						mapped_va_q.push_back(va);
						if (mapped_va_q.size() > 16) void'(mapped_va_q.pop_front());
					end
				end else if (kind < 70 && mapped_va_q.size() != 0) begin
					// revisit an earlier mapping, possibly overwritten since
					rnd = rand64();
					va = mapped_va_q[$urandom_range(mapped_va_q.size() - 1)];
					va[OFF_W-1:0] = rnd[OFF_W-1:0];
					send_beat(CMD_XLATE, rnd[WIDX_W+11:12], rand64(), va,
						1'b0, '0, 1'b0);
				end else if (kind < 85) begin
					// unmapped address, almost always a fault
					rnd = rand64();
					send_beat(CMD_XLATE, rnd[63:51], rand64(), rnd[VA_W-1:0],
						1'b0, '0, 1'b0);
				end else if (kind < 99) begin
					// stray write anywhere in the store
					rnd = rand64();
					send_beat(CMD_WRITE, rnd[WIDX_W-1:0], rand64(), rnd[63:25],
						1'b0, '0, 1'b0);
				end else begin
					// pause the sender until the pipe is empty
					drain();
				end
			end
		end

		// let the last results come back, then let the clock run on before the verdict
		drain();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
